### rtl/gyro_bias_calibrate_normalize_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gyro bias calibrate and normalize unit
// Each macro expands to a concurrent assertion in simulation and to nothing
// in synthesis.
// ----------------------------------------------------------------------------
`ifndef GYRO_BIAS_CALIBRATE_NORMALIZE_UNIT_MACROS_SVH
`define GYRO_BIAS_CALIBRATE_NORMALIZE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define GBCN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gbcn: implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define GBCN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gbcn: next-cycle check failed");
`else
`define GBCN_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GBCN_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/gbcn_pkg.sv
// ----------------------------------------------------------------------------
// gbcn_pkg
// Microcode program, control word layout and shared constants of the gyro
// bias calibrate and normalize unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gbcn_pkg;

  typedef logic [3:0] pc_t;

  // Datapath operations selected by one control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_MUL,
    OP_ADDSQ,
    OP_CHECK,
    OP_LDSQ,
    OP_DIV,
    OP_LDSUM,
    OP_OFF,
    OP_LDROOT,
    OP_ROOT,
    OP_THR,
    OP_DIFF,
    OP_EMIT
  } op_t;

  // Jump conditions; when false the step counter advances by one.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOACC,
    COND_NORM,
    COND_AXIS,
    COND_CNT,
    COND_NOTDONE,
    COND_FULL
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  // Status flags from the datapath that the sequencer branches on.
  typedef struct packed {
    logic acc;
    logic norm;
    logic axis_more;
    logic cnt_nz;
    logic not_done;
    logic full;
  } flags_t;

  // Program addresses.
  localparam pc_t A_WAIT   = 4'd0;
  localparam pc_t A_DISP   = 4'd1;
  localparam pc_t A_MUL    = 4'd2;
  localparam pc_t A_ADDSQ  = 4'd3;
  localparam pc_t A_CHECK  = 4'd4;
  localparam pc_t A_LDSQ   = 4'd5;
  localparam pc_t A_DIV1   = 4'd6;
  localparam pc_t A_LDSUM  = 4'd7;
  localparam pc_t A_DIV2   = 4'd8;
  localparam pc_t A_OFF    = 4'd9;
  localparam pc_t A_LDROOT = 4'd10;
  localparam pc_t A_ROOT   = 4'd11;
  localparam pc_t A_THR    = 4'd12;
  localparam pc_t A_DIFF   = 4'd13;
  localparam pc_t A_EMIT   = 4'd14;
  localparam pc_t A_RET    = 4'd15;

  localparam int NUM_AXES   = 3;
  localparam int DIV_W      = 40;
  localparam int ROOT_W     = 31;
  localparam int CNT_W      = 6;
  localparam int ROOT_STEPS = 16;

  localparam logic [1:0]       AXIS_LAST     = 2'd2;
  localparam logic [7:0]       COUNT_RESET   = 8'd16;
  localparam logic [CNT_W-1:0] DIV_LAST      = CNT_W'(DIV_W - 1);
  localparam logic [CNT_W-1:0] ROOT_LAST     = CNT_W'(ROOT_STEPS - 1);
  localparam logic [ROOT_W-1:0] ROOT_BIT_TOP = ROOT_W'(1) << (ROOT_W - 1);
  localparam logic [14:0]      THR_MAX       = 15'h7FFF;

  // Read-only microcode store.
  function automatic ctrl_t rom_word(input pc_t pc);
    ctrl_t w;
    begin
      w = '{op: OP_NOP, cond: COND_NEVER, target: A_WAIT};
      case (pc)
        A_WAIT:   w = '{op: OP_LATCH,  cond: COND_NOACC,   target: A_WAIT};
        A_DISP:   w = '{op: OP_NOP,    cond: COND_NORM,    target: A_DIFF};
        A_MUL:    w = '{op: OP_MUL,    cond: COND_NEVER,   target: A_WAIT};
        A_ADDSQ:  w = '{op: OP_ADDSQ,  cond: COND_AXIS,    target: A_MUL};
        A_CHECK:  w = '{op: OP_CHECK,  cond: COND_NOTDONE, target: A_EMIT};
        A_LDSQ:   w = '{op: OP_LDSQ,   cond: COND_NEVER,   target: A_WAIT};
        A_DIV1:   w = '{op: OP_DIV,    cond: COND_CNT,     target: A_DIV1};
        A_LDSUM:  w = '{op: OP_LDSUM,  cond: COND_NEVER,   target: A_WAIT};
        A_DIV2:   w = '{op: OP_DIV,    cond: COND_CNT,     target: A_DIV2};
        A_OFF:    w = '{op: OP_OFF,    cond: COND_NEVER,   target: A_WAIT};
        A_LDROOT: w = '{op: OP_LDROOT, cond: COND_NEVER,   target: A_WAIT};
        A_ROOT:   w = '{op: OP_ROOT,   cond: COND_CNT,     target: A_ROOT};
        A_THR:    w = '{op: OP_THR,    cond: COND_AXIS,    target: A_LDSQ};
        A_DIFF:   w = '{op: OP_DIFF,   cond: COND_NEVER,   target: A_WAIT};
        A_EMIT:   w = '{op: OP_EMIT,   cond: COND_FULL,    target: A_EMIT};
        A_RET:    w = '{op: OP_NOP,    cond: COND_ALWAYS,  target: A_WAIT};
        default:  w = '{op: OP_NOP,    cond: COND_ALWAYS,  target: A_WAIT};
      endcase
      return w;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/gbcn_in_if.sv
// ----------------------------------------------------------------------------
// gbcn_in_if
// Sample channel: opcode and three raw axis samples with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbcn_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [15:0] sample_x;
  logic signed [15:0] sample_y;
  logic signed [15:0] sample_z;

  modport source (output valid, opcode, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, opcode, sample_x, sample_y, sample_z, output ready);
endinterface

`default_nettype wire

### rtl/gbcn_out_if.sv
// ----------------------------------------------------------------------------
// gbcn_out_if
// Result channel: corrected samples, thresholds and run-complete flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbcn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic        [14:0] thr_x;
  logic        [14:0] thr_y;
  logic        [14:0] thr_z;
  logic               cal_done;

  modport source (output valid, out_x, out_y, out_z, thr_x, thr_y, thr_z, cal_done,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, thr_x, thr_y, thr_z, cal_done,
                  output ready);
endinterface

`default_nettype wire

### rtl/gbcn_cfg_if.sv
// ----------------------------------------------------------------------------
// gbcn_cfg_if
// Configuration write channel carrying the sample count register.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbcn_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_count;

  modport source (output valid, sample_count, input ready);
  modport sink   (input valid, sample_count, output ready);
endinterface

`default_nettype wire

### rtl/gyro_bias_calibrate_normalize_unit.sv
// ----------------------------------------------------------------------------
// Gyro bias calibrate and normalize unit
// Per-axis bias and noise estimation from calibrate transactions, and bias
// removal from normalize transactions, run by a microcoded datapath.
// ----------------------------------------------------------------------------
// Usage: a transaction on in_ch carries an opcode and three signed samples.
// Opcode 0 adds the samples to the running sums; opcode 1 asks for the
// samples minus the stored offsets. Every input transaction returns exactly
// one transaction on out_ch, with the thresholds as they stand afterwards.
// cfg_ch writes the run length; it is always ready and is meant to be
// written while the unit is idle. A run length of zero acts as one.
// Flow: in_ch is ready only at the program's wait step, so a transaction
// is accepted only once the previous one has reached the output register.
// A calibrate transaction steps one shared multiplier over the axes in
// turn; the transaction that ends a run adds, per axis, two 40-step
// restoring divides and a 16-step square root, one step a cycle.
// Reset clears sums, offsets, thresholds, the sample tally and the output
// valid flag, and sets the run length to 16. A stalled receiver holds the
// result in the output register; one more transaction can be accepted and
// worked on, and the program then waits at its emit step until room opens.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gyro_bias_calibrate_normalize_unit_macros.svh"

module gyro_bias_calibrate_normalize_unit (
  input wire logic  clk,
  input wire logic  rst_n,
  gbcn_in_if.sink   in_ch,
  gbcn_cfg_if.sink  cfg_ch,
  gbcn_out_if.source out_ch
);

  // Sequencer interface.
  gbcn_pkg::ctrl_t  ctrl;
  gbcn_pkg::pc_t    pc;
  gbcn_pkg::flags_t flags;

  // Configuration and accumulator state.
  logic        [7:0]  count_r;
  logic        [7:0]  taken_r;
  logic signed [23:0] sum_r    [gbcn_pkg::NUM_AXES];
  logic        [39:0] sumsq_r  [gbcn_pkg::NUM_AXES];
  logic signed [15:0] offset_r [gbcn_pkg::NUM_AXES];
  logic        [14:0] thr_r    [gbcn_pkg::NUM_AXES];

  // Latched transaction.
  logic               opc_r;
  logic signed [15:0] samp_r [gbcn_pkg::NUM_AXES];
  logic signed [15:0] res_r  [gbcn_pkg::NUM_AXES];
  logic               done_r;

  // Working registers of the shared units.
  logic [1:0]                      axis_r;
  logic [7:0]                      n_r;
  logic [31:0]                     prod_r;
  logic [gbcn_pkg::DIV_W-1:0]      quo_r;
  logic [7:0]                      rem_r;
  logic [gbcn_pkg::CNT_W-1:0]      cnt_r;
  logic [30:0]                     msq_r;
  logic                            neg_r;
  logic [gbcn_pkg::ROOT_W-1:0]     rad_r;
  logic [gbcn_pkg::ROOT_W-1:0]     root_r;
  logic [gbcn_pkg::ROOT_W-1:0]     bit_r;

  // Output register.
  logic               out_valid_r;
  logic signed [15:0] ox_r, oy_r, oz_r;
  logic        [14:0] tx_r, ty_r, tz_r;
  logic               od_r;

  // Combinational helpers.
  logic               accept;
  logic               room;
  logic        [7:0]  need;
  logic        [8:0]  n_next;
  logic               run_end;
  logic signed [15:0] s_sel;
  logic signed [31:0] sq_sample;
  logic        [31:0] sq_quo;
  logic signed [23:0] sum_sel;
  logic        [23:0] sum_mag;
  logic        [8:0]  div_shift;
  logic        [9:0]  div_trial;
  logic        [31:0] var_diff;
  logic        [gbcn_pkg::ROOT_W:0] root_try;
  logic               root_ge;
  logic        [15:0] off_mag;

  gbcn_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl),
    .pc    (pc)
  );

  // Handshakes.
  assign in_ch.ready  = (pc == gbcn_pkg::A_WAIT);
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign room         = !out_valid_r || out_ch.ready;

  // Run bookkeeping: the tally after this sample against the run length.
  assign need    = (count_r == 8'd0) ? 8'd1 : count_r;
  assign n_next  = {1'b0, taken_r} + 9'd1;
  assign run_end = (n_next >= {1'b0, need});

  // Shared multiplier operands and selected accumulator.
  assign s_sel     = samp_r[axis_r];
  assign sq_sample = s_sel * s_sel;
  assign sq_quo    = quo_r[15:0] * quo_r[15:0];
  assign sum_sel   = sum_r[axis_r];
  assign sum_mag   = sum_sel[23] ? 24'(-sum_sel) : 24'(sum_sel);

  // One restoring divide step by the run's sample tally.
  assign div_shift = {rem_r, quo_r[gbcn_pkg::DIV_W-1]};
  assign div_trial = {1'b0, div_shift} - {2'b00, n_r};

  // Variance as mean square minus squared mean, clamped at zero.
  assign var_diff = {1'b0, msq_r} - {1'b0, prod_r[30:0]};

  // One step of the digit-by-digit square root.
  assign root_try = {1'b0, root_r} + {1'b0, bit_r};
  assign root_ge  = ({1'b0, rad_r} >= root_try);

  // Signed offset from the quotient magnitude.
  assign off_mag = neg_r ? 16'(-quo_r[15:0]) : quo_r[15:0];

  // Branch flags.
  always_comb begin
    flags.acc       = accept;
    flags.norm      = opc_r;
    flags.axis_more = (axis_r != gbcn_pkg::AXIS_LAST);
    flags.cnt_nz    = (cnt_r != '0);
    flags.not_done  = !run_end;
    flags.full      = !room;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= gbcn_pkg::COUNT_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      count_r <= cfg_ch.sample_count;
    end
  end

  // Architectural state: accumulators, tally, offsets and thresholds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= '0;
      for (int i = 0; i < gbcn_pkg::NUM_AXES; i++) begin
        sum_r[i]    <= '0;
        sumsq_r[i]  <= '0;
        offset_r[i] <= '0;
        thr_r[i]    <= '0;
      end
    end else begin
      case (ctrl.op)
        gbcn_pkg::OP_MUL: begin
          sum_r[axis_r] <= sum_sel + 24'(s_sel);
        end
        gbcn_pkg::OP_ADDSQ: begin
          sumsq_r[axis_r] <= sumsq_r[axis_r] + {8'd0, prod_r};
        end
        gbcn_pkg::OP_CHECK: begin
          taken_r <= run_end ? 8'd0 : n_next[7:0];
        end
        gbcn_pkg::OP_OFF: begin
          offset_r[axis_r] <= off_mag;
        end
        gbcn_pkg::OP_THR: begin
          thr_r[axis_r]   <= root_r[15] ? gbcn_pkg::THR_MAX : root_r[14:0];
          sum_r[axis_r]   <= '0;
          sumsq_r[axis_r] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencing control: axis index, step counts and run-complete flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= '0;
      cnt_r  <= '0;
      opc_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      case (ctrl.op)
        gbcn_pkg::OP_LATCH: begin
          if (accept) begin
            opc_r  <= in_ch.opcode;
            done_r <= 1'b0;
            axis_r <= '0;
          end
        end
        gbcn_pkg::OP_ADDSQ, gbcn_pkg::OP_THR: begin
          axis_r <= flags.axis_more ? axis_r + 2'd1 : 2'd0;
        end
        gbcn_pkg::OP_CHECK: begin
          done_r <= run_end;
        end
        gbcn_pkg::OP_LDSQ, gbcn_pkg::OP_LDSUM: begin
          cnt_r <= gbcn_pkg::DIV_LAST;
        end
        gbcn_pkg::OP_LDROOT: begin
          cnt_r <= gbcn_pkg::ROOT_LAST;
        end
        gbcn_pkg::OP_DIV, gbcn_pkg::OP_ROOT: begin
          if (cnt_r != '0) begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath working registers.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      gbcn_pkg::OP_LATCH: begin
        if (accept) begin
          samp_r[0] <= in_ch.sample_x;
          samp_r[1] <= in_ch.sample_y;
          samp_r[2] <= in_ch.sample_z;
          for (int i = 0; i < gbcn_pkg::NUM_AXES; i++) begin
            res_r[i] <= '0;
          end
        end
      end
      gbcn_pkg::OP_MUL: begin
        prod_r <= 32'(sq_sample);
      end
      gbcn_pkg::OP_CHECK: begin
        n_r <= n_next[7:0];
      end
      gbcn_pkg::OP_LDSQ: begin
        quo_r <= sumsq_r[axis_r];
        rem_r <= '0;
      end
      gbcn_pkg::OP_DIV: begin
        if (!div_trial[9]) begin
          rem_r <= div_trial[7:0];
          quo_r <= {quo_r[gbcn_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem_r <= div_shift[7:0];
          quo_r <= {quo_r[gbcn_pkg::DIV_W-2:0], 1'b0};
        end
      end
      gbcn_pkg::OP_LDSUM: begin
        msq_r <= quo_r[30:0];
        neg_r <= sum_sel[23];
        quo_r <= {16'd0, sum_mag};
        rem_r <= '0;
      end
      gbcn_pkg::OP_OFF: begin
        prod_r <= sq_quo;
      end
      gbcn_pkg::OP_LDROOT: begin
        rad_r  <= var_diff[31] ? '0 : var_diff[30:0];
        root_r <= '0;
        bit_r  <= gbcn_pkg::ROOT_BIT_TOP;
      end
      gbcn_pkg::OP_ROOT: begin
        if (root_ge) begin
          rad_r  <= rad_r - root_try[gbcn_pkg::ROOT_W-1:0];
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      gbcn_pkg::OP_DIFF: begin
        // The run-ending calibrate path also passes here; its result stays zero.
        if (opc_r) begin
          for (int i = 0; i < gbcn_pkg::NUM_AXES; i++) begin
            res_r[i] <= samp_r[i] - offset_r[i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.op == gbcn_pkg::OP_EMIT && room) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (ctrl.op == gbcn_pkg::OP_EMIT && room) begin
      ox_r <= res_r[0];
      oy_r <= res_r[1];
      oz_r <= res_r[2];
      tx_r <= thr_r[0];
      ty_r <= thr_r[1];
      tz_r <= thr_r[2];
      od_r <= done_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_x    = ox_r;
  assign out_ch.out_y    = oy_r;
  assign out_ch.out_z    = oz_r;
  assign out_ch.thr_x    = tx_r;
  assign out_ch.thr_y    = ty_r;
  assign out_ch.thr_z    = tz_r;
  assign out_ch.cal_done = od_r;

  // An accepted transaction always moves on to the dispatch step.
  `GBCN_ASSERT_NXT(a_accept_dispatch, clk, rst_n, accept, pc == gbcn_pkg::A_DISP)
  // The output register fills only from the emit step.
  `GBCN_ASSERT_IMP(a_fill_from_emit, clk, rst_n, $rose(out_valid_r), $past(pc) == gbcn_pkg::A_EMIT)
  // The mean magnitude must fit a 16-bit offset.
  `GBCN_ASSERT_IMP(a_mean_range, clk, rst_n, ctrl.op == gbcn_pkg::OP_OFF, quo_r[39:16] == 24'd0)
  // The square root never exceeds the root of the largest variance.
  `GBCN_ASSERT_IMP(a_root_range, clk, rst_n, ctrl.op == gbcn_pkg::OP_THR, root_r <= 31'd32768)

endmodule

`default_nettype wire

### rtl/gbcn_seq.sv
// ----------------------------------------------------------------------------
// gbcn_seq
// Microcode sequencer: step counter, program store and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module gbcn_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire gbcn_pkg::flags_t flags,
  output gbcn_pkg::ctrl_t      ctrl,
  output gbcn_pkg::pc_t        pc
);

  gbcn_pkg::pc_t pc_r;
  gbcn_pkg::pc_t pc_nxt;
  logic          take;

  // Current control word comes straight out of the program store.
  assign ctrl = gbcn_pkg::rom_word(pc_r);
  assign pc   = pc_r;

  // Evaluate the jump condition of this step.
  always_comb begin
    take = 1'b0;
    unique case (ctrl.cond)
      gbcn_pkg::COND_NEVER:   take = 1'b0;
      gbcn_pkg::COND_ALWAYS:  take = 1'b1;
      gbcn_pkg::COND_NOACC:   take = !flags.acc;
      gbcn_pkg::COND_NORM:    take = flags.norm;
      gbcn_pkg::COND_AXIS:    take = flags.axis_more;
      gbcn_pkg::COND_CNT:     take = flags.cnt_nz;
      gbcn_pkg::COND_NOTDONE: take = flags.not_done;
      gbcn_pkg::COND_FULL:    take = flags.full;
      default:                take = 1'b0;
    endcase
    pc_nxt = take ? ctrl.target : pc_r + 4'd1;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= gbcn_pkg::A_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire
